FILE: design/cpid_pkg.sv
// Shared types, constants and saturation helper for the clamped PID step block.
package cpid_pkg;

    localparam int Q_BITS   = 16;
    localparam int DATA_W   = 16;
    localparam int GAIN_W   = 32;
    localparam int LIM_W    = 15;
    localparam int ERR_W    = 34;
    localparam int DIFF_W   = 35;
    localparam int MAG_W    = 33;
    localparam int TERM_W   = 32;
    localparam int SUM_W    = 34;
    localparam int SAT_W    = 50;
    localparam int CFG_IDX_W = 8;

    // Gear ratio division is done as a multiplication by a rounded-up reciprocal.
    // The shift covers a 32-bit dividend and the largest allowed ratio, which keeps
    // the quotient exact for every input.
    localparam int GEAR_RATIO     = 1;
    localparam int GEAR_RATIO_MAX = 64;
    localparam int GEAR_SHIFT     = 32 + $clog2(GEAR_RATIO_MAX);
    localparam int RECIP_W        = GEAR_SHIFT + 1;
    localparam logic [RECIP_W-1:0] GEAR_RECIP =
        RECIP_W'(((65'd1 << GEAR_SHIFT) + 65'(GEAR_RATIO) - 65'd1) / 65'(GEAR_RATIO));

    localparam logic signed [DIFF_W-1:0] SLEW_STEP_Q = DIFF_W'(3000 * 65536);

    localparam logic [LIM_W-1:0] LIMIT_RESET = 15'h7FFF;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_P_LIMIT  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_I_LIMIT  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_D_LIMIT  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 8'd7;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [LIM_W-1:0]  p_lim;
        logic [LIM_W-1:0]  i_lim;
        logic [LIM_W-1:0]  d_lim;
        logic [LIM_W-1:0]  drive_lim;
        logic [LIM_W-1:0]  deadband;
    } cfg_t;

    // Symmetric saturation of a Q16.16 value at +-lim.
    function automatic logic signed [TERM_W-1:0] sat_q(
        input logic signed [SAT_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [SAT_W-1:0] l;
        l = $signed({{(SAT_W-LIM_W-Q_BITS){1'b0}}, lim, {Q_BITS{1'b0}}});
        if (v > l)
        begin
            return TERM_W'(l);
        end
        else if (v < -l)
        begin
            return TERM_W'(-l);
        end
        else
        begin
            return TERM_W'(v);
        end
    endfunction

endpackage

FILE: design/cpid_error_stage.sv
// Input register, gear ratio division, deadbanded error and error difference.
module cpid_error_stage (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_fire,
    input  logic signed [cpid_pkg::DATA_W-1:0]   target,
    input  logic signed [cpid_pkg::DATA_W-1:0]   measured,
    input  logic [cpid_pkg::LIM_W-1:0]           deadband,
    output logic                                 b_valid,
    output logic signed [cpid_pkg::ERR_W-1:0]    b_err,
    output logic signed [cpid_pkg::DIFF_W-1:0]   b_ediff,
    output logic                                 b_moving
);

    localparam int PROD_W = cpid_pkg::DATA_W + cpid_pkg::RECIP_W;
    localparam int GEARED_W = 32;

    logic                                 a_valid_reg;
    logic signed [cpid_pkg::DATA_W-1:0]   a_target_reg;
    logic signed [cpid_pkg::DATA_W-1:0]   a_measured_reg;
    logic signed [cpid_pkg::ERR_W-1:0]    prev_err_reg;
    logic                                 b_valid_reg;
    logic signed [cpid_pkg::ERR_W-1:0]    b_err_reg;
    logic signed [cpid_pkg::DIFF_W-1:0]   b_ediff_reg;
    logic                                 b_moving_reg;

    logic                                 meas_neg;
    logic [cpid_pkg::DATA_W-1:0]          meas_mag;
    logic [PROD_W-1:0]                    recip_prod;
    logic [GEARED_W-1:0]                  geared_mag;
    logic signed [cpid_pkg::ERR_W-1:0]    geared;
    logic signed [cpid_pkg::ERR_W-1:0]    target_q;
    logic signed [cpid_pkg::ERR_W-1:0]    err_raw;
    logic [cpid_pkg::ERR_W-1:0]           err_mag;
    logic [cpid_pkg::ERR_W-1:0]           band_q;
    logic signed [cpid_pkg::ERR_W-1:0]    err;
    logic signed [cpid_pkg::DIFF_W-1:0]   ediff;

    always_comb
    begin
        meas_neg   = a_measured_reg[cpid_pkg::DATA_W-1];
        meas_mag   = meas_neg ? cpid_pkg::DATA_W'(-a_measured_reg)
                              : cpid_pkg::DATA_W'(a_measured_reg);
        recip_prod = PROD_W'(meas_mag) * PROD_W'(cpid_pkg::GEAR_RECIP);
        geared_mag = GEARED_W'(recip_prod >> (cpid_pkg::GEAR_SHIFT - cpid_pkg::Q_BITS));
        geared     = meas_neg ? -$signed({2'b00, geared_mag}) : $signed({2'b00, geared_mag});
        target_q   = $signed({{2{a_target_reg[cpid_pkg::DATA_W-1]}}, a_target_reg,
                              {cpid_pkg::Q_BITS{1'b0}}});
        err_raw    = target_q - geared;
        err_mag    = err_raw[cpid_pkg::ERR_W-1] ? cpid_pkg::ERR_W'(-err_raw)
                                                : cpid_pkg::ERR_W'(err_raw);
        band_q     = {{(cpid_pkg::ERR_W-cpid_pkg::LIM_W-cpid_pkg::Q_BITS){1'b0}},
                      deadband, {cpid_pkg::Q_BITS{1'b0}}};
        err        = (err_mag < band_q) ? '0 : err_raw;
        ediff      = cpid_pkg::DIFF_W'(err) - cpid_pkg::DIFF_W'(prev_err_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            prev_err_reg <= '0;
        end
        else if (en)
        begin
            a_valid_reg <= in_fire;
            b_valid_reg <= a_valid_reg;
            if (a_valid_reg)
            begin
                prev_err_reg <= err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_fire)
        begin
            a_target_reg   <= target;
            a_measured_reg <= measured;
        end
        if (en && a_valid_reg)
        begin
            b_err_reg    <= err;
            b_ediff_reg  <= ediff;
            b_moving_reg <= (geared_mag != '0);
        end
    end

    assign b_valid  = b_valid_reg;
    assign b_err    = b_err_reg;
    assign b_ediff  = b_ediff_reg;
    assign b_moving = b_moving_reg;

endmodule

FILE: design/cpid_term_stage.sv
// Gain multipliers, per-term saturation and the integral accumulator.
module cpid_term_stage (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  cpid_pkg::cfg_t                       cfg,
    input  logic                                 b_valid,
    input  logic signed [cpid_pkg::ERR_W-1:0]    b_err,
    input  logic signed [cpid_pkg::DIFF_W-1:0]   b_ediff,
    input  logic                                 b_moving,
    output logic                                 c_valid,
    output logic signed [cpid_pkg::TERM_W-1:0]   c_p,
    output logic signed [cpid_pkg::TERM_W-1:0]   c_i,
    output logic signed [cpid_pkg::TERM_W-1:0]   c_d,
    output logic                                 c_moving
);

    localparam int PROD_W = cpid_pkg::GAIN_W + cpid_pkg::MAG_W;

    // Product of gain and value shifted down by 16, magnitude truncated, sign restored.
    function automatic logic signed [cpid_pkg::SAT_W-1:0] qmul(
        input logic [cpid_pkg::GAIN_W-1:0]        gain,
        input logic signed [cpid_pkg::DIFF_W-1:0] x
    );
        logic [cpid_pkg::MAG_W-1:0]  ax;
        logic [PROD_W-1:0]           prod;
        logic signed [cpid_pkg::SAT_W-1:0] m;
        ax   = x[cpid_pkg::DIFF_W-1] ? cpid_pkg::MAG_W'(-x) : cpid_pkg::MAG_W'(x);
        prod = PROD_W'(gain) * PROD_W'(ax);
        m    = $signed({1'b0, prod[cpid_pkg::Q_BITS +: (cpid_pkg::SAT_W-1)]});
        return x[cpid_pkg::DIFF_W-1] ? -m : m;
    endfunction

    logic                                 c_valid_reg;
    logic signed [cpid_pkg::TERM_W-1:0]   c_p_reg;
    logic signed [cpid_pkg::TERM_W-1:0]   c_d_reg;
    logic                                 c_moving_reg;
    logic signed [cpid_pkg::TERM_W-1:0]   integral_reg;

    logic signed [cpid_pkg::SAT_W-1:0]    p_prod;
    logic signed [cpid_pkg::SAT_W-1:0]    i_prod;
    logic signed [cpid_pkg::SAT_W-1:0]    d_prod;
    logic signed [cpid_pkg::TERM_W-1:0]   p_term;
    logic signed [cpid_pkg::TERM_W-1:0]   d_term;
    logic signed [cpid_pkg::TERM_W-1:0]   integral_next;

    always_comb
    begin
        p_prod        = qmul(cfg.gain_p, cpid_pkg::DIFF_W'(b_err));
        i_prod        = qmul(cfg.gain_i, cpid_pkg::DIFF_W'(b_err));
        d_prod        = qmul(cfg.gain_d, b_ediff);
        p_term        = cpid_pkg::sat_q(p_prod, cfg.p_lim);
        d_term        = cpid_pkg::sat_q(d_prod, cfg.d_lim);
        integral_next = cpid_pkg::sat_q(cpid_pkg::SAT_W'(integral_reg) + i_prod, cfg.i_lim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg  <= 1'b0;
            integral_reg <= '0;
        end
        else if (en)
        begin
            c_valid_reg <= b_valid;
            if (b_valid)
            begin
                integral_reg <= integral_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && b_valid)
        begin
            c_p_reg      <= p_term;
            c_d_reg      <= d_term;
            c_moving_reg <= b_moving;
        end
    end

    // The accumulator is updated on the same edge as the stage registers,
    // so it already holds this item's integral term.
    assign c_valid  = c_valid_reg;
    assign c_p      = c_p_reg;
    assign c_i      = integral_reg;
    assign c_d      = c_d_reg;
    assign c_moving = c_moving_reg;

endmodule

FILE: design/cpid_output_stage.sv
// Term sum, slew limiting against the last drive, output saturation and result register.
module cpid_output_stage (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic [cpid_pkg::LIM_W-1:0]           drive_lim,
    input  logic                                 c_valid,
    input  logic signed [cpid_pkg::TERM_W-1:0]   c_p,
    input  logic signed [cpid_pkg::TERM_W-1:0]   c_i,
    input  logic signed [cpid_pkg::TERM_W-1:0]   c_d,
    input  logic                                 c_moving,
    output logic                                 out_valid,
    output logic signed [cpid_pkg::DATA_W-1:0]   drive
);

    logic                                 out_valid_reg;
    logic signed [cpid_pkg::DATA_W-1:0]   drive_reg;
    logic signed [cpid_pkg::TERM_W-1:0]   prev_drive_reg;

    logic signed [cpid_pkg::SUM_W-1:0]    sum;
    logic signed [cpid_pkg::DIFF_W-1:0]   diff;
    logic                                 too_fast;
    logic signed [cpid_pkg::SUM_W-1:0]    slewed;
    logic signed [cpid_pkg::TERM_W-1:0]   drive_q;
    logic signed [cpid_pkg::TERM_W:0]     rounded;

    always_comb
    begin
        sum      = cpid_pkg::SUM_W'(c_p) + cpid_pkg::SUM_W'(c_i) + cpid_pkg::SUM_W'(c_d);
        diff     = cpid_pkg::DIFF_W'(sum) - cpid_pkg::DIFF_W'(prev_drive_reg);
        too_fast = c_moving && ((diff > cpid_pkg::SLEW_STEP_Q) || (diff < -cpid_pkg::SLEW_STEP_Q));
        if (!too_fast)
        begin
            slewed = sum;
        end
        else if (diff > 0)
        begin
            slewed = cpid_pkg::SUM_W'(prev_drive_reg) + cpid_pkg::SUM_W'(cpid_pkg::SLEW_STEP_Q);
        end
        else
        begin
            slewed = cpid_pkg::SUM_W'(prev_drive_reg) - cpid_pkg::SUM_W'(cpid_pkg::SLEW_STEP_Q);
        end
        drive_q = cpid_pkg::sat_q(cpid_pkg::SAT_W'(slewed), drive_lim);
        // Bias negative values so the shift truncates toward zero.
        rounded = (cpid_pkg::TERM_W+1)'(drive_q)
                + (drive_q[cpid_pkg::TERM_W-1] ? (cpid_pkg::TERM_W+1)'(16'hFFFF) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            prev_drive_reg <= '0;
        end
        else if (en)
        begin
            out_valid_reg <= c_valid;
            if (c_valid)
            begin
                prev_drive_reg <= drive_q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && c_valid)
        begin
            drive_reg <= rounded[cpid_pkg::Q_BITS +: cpid_pkg::DATA_W];
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

endmodule

FILE: design/clamped_pid_step.sv
// Top level of the clamped PID step: configuration registers, flow control, stages.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+----------------------------------
//  input   | in_valid / in_ready    | target, measured
//  output  | out_valid / out_ready  | drive
//  config  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; each item passes from its input beat
// to its output beat through the input register, error stage, term stage and result register.
// The integral, last error and last drive feedback loops each close within one stage.
// A stalled output beat holds the whole pipeline; in_ready is low only then.
// Reset clears the feedback state and loads the register defaults; cfg_ready is always high.
module clamped_pid_step (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [cpid_pkg::DATA_W-1:0]    target,
    input  logic signed [cpid_pkg::DATA_W-1:0]    measured,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [cpid_pkg::DATA_W-1:0]    drive,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cpid_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cpid_pkg::GAIN_W-1:0]           cfg_data
);

    cpid_pkg::cfg_t                       cfg_reg;
    logic                                 en;
    logic                                 in_fire;
    logic                                 b_valid;
    logic signed [cpid_pkg::ERR_W-1:0]    b_err;
    logic signed [cpid_pkg::DIFF_W-1:0]   b_ediff;
    logic                                 b_moving;
    logic                                 c_valid;
    logic signed [cpid_pkg::TERM_W-1:0]   c_p;
    logic signed [cpid_pkg::TERM_W-1:0]   c_i;
    logic signed [cpid_pkg::TERM_W-1:0]   c_d;
    logic                                 c_moving;

    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign in_fire   = in_valid && en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p    <= '0;
            cfg_reg.gain_i    <= '0;
            cfg_reg.gain_d    <= '0;
            cfg_reg.p_lim     <= cpid_pkg::LIMIT_RESET;
            cfg_reg.i_lim     <= cpid_pkg::LIMIT_RESET;
            cfg_reg.d_lim     <= cpid_pkg::LIMIT_RESET;
            cfg_reg.drive_lim <= cpid_pkg::LIMIT_RESET;
            cfg_reg.deadband  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cpid_pkg::REG_GAIN_P:      cfg_reg.gain_p    <= cfg_data;
                cpid_pkg::REG_GAIN_I:      cfg_reg.gain_i    <= cfg_data;
                cpid_pkg::REG_GAIN_D:      cfg_reg.gain_d    <= cfg_data;
                cpid_pkg::REG_P_LIMIT:     cfg_reg.p_lim     <= cfg_data[cpid_pkg::LIM_W-1:0];
                cpid_pkg::REG_I_LIMIT:     cfg_reg.i_lim     <= cfg_data[cpid_pkg::LIM_W-1:0];
                cpid_pkg::REG_D_LIMIT:     cfg_reg.d_lim     <= cfg_data[cpid_pkg::LIM_W-1:0];
                cpid_pkg::REG_DRIVE_LIMIT: cfg_reg.drive_lim <= cfg_data[cpid_pkg::LIM_W-1:0];
                cpid_pkg::REG_DEADBAND:    cfg_reg.deadband  <= cfg_data[cpid_pkg::LIM_W-1:0];
                default:                   ;
            endcase
        end
    end

    cpid_error_stage u_error (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_fire  (in_fire),
        .target   (target),
        .measured (measured),
        .deadband (cfg_reg.deadband),
        .b_valid  (b_valid),
        .b_err    (b_err),
        .b_ediff  (b_ediff),
        .b_moving (b_moving)
    );

    cpid_term_stage u_term (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .cfg      (cfg_reg),
        .b_valid  (b_valid),
        .b_err    (b_err),
        .b_ediff  (b_ediff),
        .b_moving (b_moving),
        .c_valid  (c_valid),
        .c_p      (c_p),
        .c_i      (c_i),
        .c_d      (c_d),
        .c_moving (c_moving)
    );

    cpid_output_stage u_output (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .drive_lim (cfg_reg.drive_lim),
        .c_valid   (c_valid),
        .c_p       (c_p),
        .c_i       (c_i),
        .c_d       (c_d),
        .c_moving  (c_moving),
        .out_valid (out_valid),
        .drive     (drive)
    );

    // A presented drive never exceeds the configured output bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(drive) <= $signed({1'b0, cfg_reg.drive_lim}))
                   && ($signed(drive) >= -$signed({1'b0, cfg_reg.drive_lim})))
        else $error("drive beat outside the configured drive limit");

    // An accepted input beat reaches the result register once it has advanced through every stage without a stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire ##1 en ##1 en ##1 en |=> out_valid)
        else $error("accepted input beat did not reach the output");

    // The integral term stays within its largest possible bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        c_valid |-> (c_i <= $signed({1'b0, cpid_pkg::LIMIT_RESET, 16'h0000}))
                 && (c_i >= -$signed({1'b0, cpid_pkg::LIMIT_RESET, 16'h0000})))
        else $error("integral term outside the representable bound");

endmodule

FILE: verif/clamped_pid_step_tb.sv
// Self-checking testbench for the clamped PID step block, using a cycle-free software predictor.
`timescale 1ns / 1ps

module clamped_pid_step_tb;

    typedef longint unsigned mag_t;
    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t                           kind;
        logic [cpid_pkg::CFG_IDX_W-1:0]      idx;
        logic [cpid_pkg::GAIN_W-1:0]         data;
        logic signed [cpid_pkg::DATA_W-1:0]  tgt;
        logic signed [cpid_pkg::DATA_W-1:0]  meas;
        logic                                typed;
        logic signed [cpid_pkg::DATA_W-1:0]  drive;
    } directed_row_t;

    localparam longint Q_ONE = 65536;
    localparam longint MAX_SLEW_Q = 3000 * 65536;
    localparam int PIPE_DEPTH = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTINGS = 8;
    localparam int ITEMS_PER_SETTING = 237;
    localparam int N_ROWS = 27;

    // Indexes past the register file; writes there must change nothing.
    localparam logic [cpid_pkg::CFG_IDX_W-1:0] IDX_PAST_END = 8'd8;
    localparam logic [cpid_pkg::CFG_IDX_W-1:0] IDX_TOP      = 8'hFF;

    logic                                 clk;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic signed [cpid_pkg::DATA_W-1:0]   target = '0;
    logic signed [cpid_pkg::DATA_W-1:0]   measured = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic signed [cpid_pkg::DATA_W-1:0]   drive;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [cpid_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [cpid_pkg::GAIN_W-1:0]          cfg_data = '0;

    cpid_pkg::cfg_t ctl_regs;
    longint integ_acc;
    longint last_err;
    longint last_drive;

    logic signed [cpid_pkg::DATA_W-1:0] pending_drive[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    directed_row_t directed_rows [N_ROWS] = '{
        '{ROW_WRITE,  IDX_PAST_END, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_WRITE,  IDX_TOP, 32'h0001_0000, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, cpid_pkg::REG_GAIN_P, 32'h0, 16'sh7FFF, -16'sh8000, 1'b1, 16'sd0},
        '{ROW_SAMPLE, cpid_pkg::REG_GAIN_P, 32'h0, -16'sh8000, 16'sh7FFF, 1'b1, 16'sd0},
        '{ROW_SAMPLE, cpid_pkg::REG_GAIN_P, 32'h0, 16'sd0, 16'sd0, 1'b1, 16'sd0},
        '{ROW_WRITE,  cpid_pkg::REG_GAIN_P, 32'h0001_0000, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, cpid_pkg::REG_GAIN_P, 32'h0, 16'sd100, 16'sd0, 1'b1, 16'sd100},
        '{ROW_SAMPLE, cpid_pkg::REG_GAIN_P, 32'h0, 16'sh7FFF, -16'sh8000, 1'b0, 16'sd0},
        '{ROW_SAMPLE, cpid_pkg::REG_GAIN_P, 32'h0, -16'sh8000, 16'sh7FFF, 1'b0, 16'sd0},
        '{ROW_WRITE,  cpid_pkg::REG_GAIN_I, 32'h0000_8000, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_WRITE,  cpid_pkg::REG_GAIN_D, 32'h0002_0000, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_WRITE,  cpid_pkg::REG_DEADBAND, 32'hFFFF_000A, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, cpid_pkg::REG_GAIN_P, 32'h0, 16'sd5, 16'sd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, cpid_pkg::REG_GAIN_P, 32'h0, 16'sd10, 16'sd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, cpid_pkg::REG_GAIN_P, 32'h0, -16'sd9, 16'sd1, 1'b0, 16'sd0},
        '{ROW_WRITE,  cpid_pkg::REG_P_LIMIT, 32'h0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_WRITE,  cpid_pkg::REG_I_LIMIT, 32'h0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_WRITE,  cpid_pkg::REG_D_LIMIT, 32'h0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, cpid_pkg::REG_GAIN_P, 32'h0, 16'sh7FFF, 16'sd0, 1'b1, 16'sd0},
        '{ROW_WRITE,  cpid_pkg::REG_P_LIMIT, 32'h0000_7FFF, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_WRITE,  cpid_pkg::REG_DRIVE_LIMIT, 32'h0, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, cpid_pkg::REG_GAIN_P, 32'h0, 16'sd1000, 16'sd0, 1'b1, 16'sd0},
        '{ROW_WRITE,  cpid_pkg::REG_DRIVE_LIMIT, 32'h0000_7FFF, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_WRITE,  cpid_pkg::REG_DEADBAND, 32'h0000_7FFF, 16'sd0, 16'sd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, cpid_pkg::REG_GAIN_P, 32'h0, 16'sh7FFE, 16'sd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, cpid_pkg::REG_GAIN_P, 32'h0, -16'sh8000, 16'sd0, 1'b0, 16'sd0},
        '{ROW_SAMPLE, cpid_pkg::REG_GAIN_P, 32'h0, 16'sh7FFF, -16'sd1, 1'b0, 16'sd0}
    };

    clamped_pid_step uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .target    (target),
        .measured  (measured),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Gain times value in Q16.16: the magnitude is truncated, then the sign is applied.
    function automatic longint scale_gain(input logic [cpid_pkg::GAIN_W-1:0] gain,
                                          input longint x);
        mag_t ax;
        mag_t whole;
        mag_t frac;
        ax = (x < 0) ? mag_t'(-x) : mag_t'(x);
        whole = mag_t'(gain[31:16]) * ax;
        frac = (mag_t'(gain[15:0]) * ax) >> 16;
        return (x < 0) ? -longint'(whole + frac) : longint'(whole + frac);
    endfunction

    function automatic longint saturate(input longint v, input logic [cpid_pkg::LIM_W-1:0] lim);
        longint bound;
        bound = longint'(lim) * Q_ONE;
        if (v > bound)
        begin
            return bound;
        end
        else if (v < -bound)
        begin
            return -bound;
        end
        return v;
    endfunction

    function automatic logic signed [cpid_pkg::DATA_W-1:0] fit16(input int v);
        if (v > 32767)
        begin
            return 16'sh7FFF;
        end
        else if (v < -32768)
        begin
            return -16'sh8000;
        end
        return 16'(v);
    endfunction

    // Advances the controller state by one sample and returns the drive it produces.
    function automatic logic signed [cpid_pkg::DATA_W-1:0] compute_drive(
        input logic signed [cpid_pkg::DATA_W-1:0] tgt,
        input logic signed [cpid_pkg::DATA_W-1:0] meas
    );
        longint geared;
        longint err;
        longint mag;
        longint p_part;
        longint d_part;
        longint sum;
        longint step;
        geared = (longint'(meas) * Q_ONE) / cpid_pkg::GEAR_RATIO;
        err = longint'(tgt) * Q_ONE - geared;
        mag = (err < 0) ? -err : err;
        if (mag < longint'(ctl_regs.deadband) * Q_ONE)
        begin
            err = 0;
        end
        p_part = saturate(scale_gain(ctl_regs.gain_p, err), ctl_regs.p_lim);
        integ_acc = saturate(integ_acc + scale_gain(ctl_regs.gain_i, err), ctl_regs.i_lim);
        d_part = saturate(scale_gain(ctl_regs.gain_d, err - last_err), ctl_regs.d_lim);
        sum = p_part + integ_acc + d_part;
        step = sum - last_drive;
        if (step < 0)
        begin
            step = -step;
        end
        // The slew limit only applies while the geared measurement is nonzero.
        if (step > MAX_SLEW_Q && geared != 0)
        begin
            sum = (sum > last_drive) ? last_drive + MAX_SLEW_Q : last_drive - MAX_SLEW_Q;
        end
        last_drive = saturate(sum, ctl_regs.drive_lim);
        last_err = err;
        return 16'(last_drive / Q_ONE);
    endfunction

    function automatic logic [cpid_pkg::GAIN_W-1:0] pick_gain(input int setting);
        int r;
        r = $urandom_range(9);
        if (setting == 0)
        begin
            return '1;
        end
        else if (setting == 1)
        begin
            return ($urandom_range(3) == 0) ? '0 : cpid_pkg::GAIN_W'($urandom);
        end
        else if (r < 5)
        begin
            return $urandom_range(0, 32'h0004_0000);
        end
        else if (r < 7)
        begin
            return $urandom_range(0, 32'h0000_FFFF);
        end
        else if (r < 8)
        begin
            return '0;
        end
        return $urandom;
    endfunction

    function automatic logic [cpid_pkg::LIM_W-1:0] pick_limit(input int setting);
        int r;
        r = $urandom_range(7);
        if (setting == 0)
        begin
            return cpid_pkg::LIMIT_RESET;
        end
        else if (setting == 1 || r == 0)
        begin
            return '0;
        end
        else if (r == 1)
        begin
            return cpid_pkg::LIMIT_RESET;
        end
        else if (r < 5)
        begin
            return cpid_pkg::LIM_W'($urandom_range(1, 2000));
        end
        return cpid_pkg::LIM_W'($urandom_range(1, 32767));
    endfunction

    task automatic write_reg(input logic [cpid_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cpid_pkg::GAIN_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            cpid_pkg::REG_GAIN_P:      ctl_regs.gain_p = data;
            cpid_pkg::REG_GAIN_I:      ctl_regs.gain_i = data;
            cpid_pkg::REG_GAIN_D:      ctl_regs.gain_d = data;
            cpid_pkg::REG_P_LIMIT:     ctl_regs.p_lim = data[cpid_pkg::LIM_W-1:0];
            cpid_pkg::REG_I_LIMIT:     ctl_regs.i_lim = data[cpid_pkg::LIM_W-1:0];
            cpid_pkg::REG_D_LIMIT:     ctl_regs.d_lim = data[cpid_pkg::LIM_W-1:0];
            cpid_pkg::REG_DRIVE_LIMIT: ctl_regs.drive_lim = data[cpid_pkg::LIM_W-1:0];
            cpid_pkg::REG_DEADBAND:    ctl_regs.deadband = data[cpid_pkg::LIM_W-1:0];
            default:                   ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // The 15-bit registers get random upper data bits, which the block must drop.
    task automatic write_limit(input logic [cpid_pkg::CFG_IDX_W-1:0] idx,
                               input logic [cpid_pkg::LIM_W-1:0] value);
        logic [cpid_pkg::GAIN_W-1:0] data;
        data = $urandom;
        data[cpid_pkg::LIM_W-1:0] = value;
        write_reg(idx, data);
    endtask

    // Holds the input side idle until every outstanding beat has come out.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_drive.size() != 0);
    endtask

    task automatic send_sample(
        input logic signed [cpid_pkg::DATA_W-1:0] tgt,
        input logic signed [cpid_pkg::DATA_W-1:0] meas,
        input logic                               typed,
        input logic signed [cpid_pkg::DATA_W-1:0] typed_drive
    );
        int gap;
        logic signed [cpid_pkg::DATA_W-1:0] predicted;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        target <= tgt;
        measured <= meas;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        predicted = compute_drive(tgt, meas);
        pending_drive.push_back(typed ? typed_drive : predicted);
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin : check_drive
        logic signed [cpid_pkg::DATA_W-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_drive.size() == 0)
            begin
                $error("drive beat with nothing expected: actual %0d", drive);
                mismatch_count++;
            end
            else
            begin
                want = pending_drive.pop_front();
                if (drive !== want)
                begin
                    $error("drive mismatch: expected %0d, actual %0d", want, drive);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int mode;
        int aim;
        logic signed [cpid_pkg::DATA_W-1:0] t;
        logic signed [cpid_pkg::DATA_W-1:0] m;
        ctl_regs.gain_p = '0;
        ctl_regs.gain_i = '0;
        ctl_regs.gain_d = '0;
        ctl_regs.p_lim = cpid_pkg::LIMIT_RESET;
        ctl_regs.i_lim = cpid_pkg::LIMIT_RESET;
        ctl_regs.d_lim = cpid_pkg::LIMIT_RESET;
        ctl_regs.drive_lim = cpid_pkg::LIMIT_RESET;
        ctl_regs.deadband = '0;
        integ_acc = 0;
        last_err = 0;
        last_drive = 0;
        aim = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                drain_pipeline();
                repeat (PIPE_DEPTH) @(posedge clk);
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end
            else
            begin
                send_sample(directed_rows[i].tgt, directed_rows[i].meas,
                            directed_rows[i].typed, directed_rows[i].drive);
            end
        end

        for (int s = 0; s < SETTINGS; s++)
        begin
            drain_pipeline();
            repeat (PIPE_DEPTH) @(posedge clk);
            case (s % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 61;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 61;
                end
                default:
                begin
                    send_idle_pct = 11;
                    stall_pct = 11;
                end
            endcase
            write_reg(cpid_pkg::REG_GAIN_P, pick_gain(s));
            write_reg(cpid_pkg::REG_GAIN_I, pick_gain(s));
            write_reg(cpid_pkg::REG_GAIN_D, pick_gain(s));
            write_limit(cpid_pkg::REG_P_LIMIT, pick_limit(s));
            write_limit(cpid_pkg::REG_I_LIMIT, pick_limit(s));
            write_limit(cpid_pkg::REG_D_LIMIT, pick_limit(s));
            write_limit(cpid_pkg::REG_DRIVE_LIMIT, pick_limit(s));
            if (s == 0)
            begin
                write_limit(cpid_pkg::REG_DEADBAND, '0);
            end
            else if (s == 1)
            begin
                write_limit(cpid_pkg::REG_DEADBAND, cpid_pkg::LIMIT_RESET);
            end
            else
            begin
                case ($urandom_range(3))
                    0: write_limit(cpid_pkg::REG_DEADBAND, '0);
                    1: write_limit(cpid_pkg::REG_DEADBAND,
                                   cpid_pkg::LIM_W'($urandom_range(1, 100)));
                    2: write_limit(cpid_pkg::REG_DEADBAND,
                                   cpid_pkg::LIM_W'($urandom_range(1, 3000)));
                    default: write_limit(cpid_pkg::REG_DEADBAND,
                                         cpid_pkg::LIM_W'($urandom_range(0, 32767)));
                endcase
            end
            if ($urandom_range(2) == 0)
            begin
                write_reg(cpid_pkg::CFG_IDX_W'($urandom_range(IDX_PAST_END, IDX_TOP)),
                          $urandom);
            end

            for (int n = 0; n < ITEMS_PER_SETTING; n++)
            begin
                if (n == ITEMS_PER_SETTING / 2)
                begin
                    drain_pipeline();
                end
                mode = $urandom_range(99);
                if (mode < 25)
                begin
                    t = 16'($urandom);
                    m = 16'($urandom);
                end
                else if (mode < 30)
                begin
                    t = $urandom_range(1) ? 16'sh7FFF : -16'sh8000;
                    case ($urandom_range(2))
                        0: m = 16'sh7FFF;
                        1: m = -16'sh8000;
                        default: m = 16'sd0;
                    endcase
                end
                else if (mode < 45)
                begin
                    // A geared measurement of zero turns the slew limit off.
                    t = fit16(aim + int'($urandom_range(0, 400)) - 200);
                    m = 16'sd0;
                    aim = int'(t);
                end
                else
                begin
                    // Tracking: the measurement follows a slowly moving target.
                    if ($urandom_range(19) == 0)
                    begin
                        aim = int'($urandom_range(0, 20000)) - 10000;
                    end
                    t = fit16(aim + int'($urandom_range(0, 200)) - 100);
                    m = fit16(int'(t) + int'($urandom_range(0, 600)) - 300);
                    aim = int'(t);
                end
                send_sample(t, m, 1'b0, 16'sd0);
            end
        end

        drain_pipeline();
        repeat (2 * PIPE_DEPTH) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
